/* hdl/hsvrgbw_pkg.sv */
// Shared types, register indexes and helper functions for the HSV to RGBW pipeline.
// Depends on nothing; every module of the block imports it.
`default_nettype none
package hsvrgbw_pkg;

    // One pixel, or one set of per-lane scale factors.
    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] w;
    } t_pix;

    typedef enum logic [1:0] {
        CFG_CORR_RED   = 2'd0,
        CFG_CORR_GREEN = 2'd1,
        CFG_CORR_BLUE  = 2'd2,
        CFG_UNUSED     = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        SEC_RED_ORANGE   = 3'd0,
        SEC_ORANGE_YEL   = 3'd1,
        SEC_YEL_GREEN    = 3'd2,
        SEC_GREEN_AQUA   = 3'd3,
        SEC_AQUA_BLUE    = 3'd4,
        SEC_BLUE_PURPLE  = 3'd5,
        SEC_PURPLE_PINK  = 3'd6,
        SEC_PINK_RED     = 3'd7
    } t_sector;

    localparam logic [7:0] CORR_RESET = 8'd255;
    localparam logic [7:0] SCALE_UNITY = 8'd255;

    // (x * (1 + s)) >> 8. The product never exceeds 255 * 256, so 16 bits hold it.
    function automatic logic [7:0] scale8(input logic [7:0] x, input logic [7:0] s);
        logic [15:0] prod;
        prod = 16'(x) * (16'(s) + 16'd1);
        return prod[15:8];
    endfunction

endpackage
`default_nettype wire

/* hdl/hsvrgbw_sector.sv */
// First pipeline stage: rainbow sector ramp, white from saturation, squared brightness.
// Depends on hsvrgbw_pkg.
`default_nettype none
module hsvrgbw_sector (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [7:0]         i_hue,
    input  wire logic [7:0]         i_saturation,
    input  wire logic [7:0]         i_brightness,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output hsvrgbw_pkg::t_pix       o_pix,
    output logic [7:0]              o_sat,
    output logic [7:0]              o_vid
);
    import hsvrgbw_pkg::*;

    logic        r_valid;
    t_pix        r_pix;
    logic [7:0]  r_sat;
    logic [7:0]  r_vid;
    t_pix        n_pix;
    logic [7:0]  n_vid;
    logic [15:0] third_prod;
    logic [6:0]  third;
    logic [8:0]  t9;
    logic [15:0] sq;
    logic        advance;

    assign o_ready = !r_valid || i_ready;
    assign advance = i_valid && o_ready;

    // The ramp is ((hue & 0x1F) << 3) / 3; multiplying by 171 and dropping nine bits is
    // exact for every multiple of eight up to 248.
    always_comb begin
        third_prod = 16'({i_hue[4:0], 3'b000}) * 16'd171;
        third      = third_prod[15:9];
        t9         = {2'b00, third};
    end

    always_comb begin
        n_pix.w = 8'd255 - i_saturation;
        case (t_sector'(i_hue[7:5]))
            SEC_RED_ORANGE: begin
                n_pix.r = 8'(9'd255 - t9);
                n_pix.g = 8'(t9);
                n_pix.b = 8'd0;
            end
            SEC_ORANGE_YEL: begin
                n_pix.r = 8'd171;
                n_pix.g = 8'(9'd85 + t9);
                n_pix.b = 8'd0;
            end
            SEC_YEL_GREEN: begin
                n_pix.r = 8'(9'd171 - (t9 << 1));
                n_pix.g = 8'(9'd170 + t9);
                n_pix.b = 8'd0;
            end
            SEC_GREEN_AQUA: begin
                n_pix.r = 8'd0;
                n_pix.g = 8'(9'd255 - t9);
                n_pix.b = 8'(t9);
            end
            SEC_AQUA_BLUE: begin
                n_pix.r = 8'd0;
                n_pix.g = 8'(9'd171 - (t9 << 1));
                n_pix.b = 8'(9'd85 + (t9 << 1));
            end
            SEC_BLUE_PURPLE: begin
                n_pix.r = 8'(t9);
                n_pix.g = 8'd0;
                n_pix.b = 8'(9'd255 - t9);
            end
            SEC_PURPLE_PINK: begin
                n_pix.r = 8'(9'd85 + t9);
                n_pix.g = 8'd0;
                n_pix.b = 8'(9'd171 - t9);
            end
            default: begin
                n_pix.r = 8'(9'd170 + t9);
                n_pix.g = 8'd0;
                n_pix.b = 8'(9'd85 - t9);
            end
        endcase
    end

    // Video-style square of brightness: never reaches zero unless brightness is zero.
    always_comb begin
        sq    = 16'(i_brightness) * 16'(i_brightness);
        n_vid = sq[15:8] + {7'd0, (i_brightness != 8'd0)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_pix <= n_pix;
            r_sat <= i_saturation;
            r_vid <= n_vid;
        end
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;
    assign o_sat   = r_sat;
    assign o_vid   = r_vid;
endmodule
`default_nettype wire

/* hdl/hsvrgbw_scale.sv */
// Pipeline stage that scales four lanes by per-lane factors, with a side byte carried along.
// Depends on hsvrgbw_pkg.
`default_nettype none
module hsvrgbw_scale (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire hsvrgbw_pkg::t_pix  i_pix,
    input  wire hsvrgbw_pkg::t_pix  i_scl,
    input  wire logic [7:0]         i_side,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output hsvrgbw_pkg::t_pix       o_pix,
    output logic [7:0]              o_side
);
    import hsvrgbw_pkg::*;

    logic       r_valid;
    t_pix       r_pix;
    logic [7:0] r_side;
    t_pix       n_pix;

    assign o_ready = !r_valid || i_ready;

    // A factor of 255 passes a lane unchanged, and a factor of 0 clears it.
    always_comb begin
        n_pix.r = scale8(i_pix.r, i_scl.r);
        n_pix.g = scale8(i_pix.g, i_scl.g);
        n_pix.b = scale8(i_pix.b, i_scl.b);
        n_pix.w = scale8(i_pix.w, i_scl.w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_pix  <= n_pix;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;
    assign o_side  = r_side;
endmodule
`default_nettype wire

/* hdl/hsv_to_rgbw_rainbow.sv */
// Top level of the rainbow HSV to RGBW converter: four-stage pipeline and correction registers.
// Depends on hsvrgbw_pkg, hsvrgbw_sector and hsvrgbw_scale.
//
// Usage: pixels enter on the input channel (i_valid / o_ready) as hue, saturation and
// brightness, and leave on the output channel (o_valid / i_ready) as red, green, blue and
// white drive levels. A transaction happens on a clock edge where valid and ready are both high.
// The pipeline has four register stages: sector ramp and brightness square, saturation
// scaling, brightness dimming, and color correction. Each scaling stage holds one 8 by 9 bit
// multiply per lane. A pixel moves through the stage registers in order, and o_valid is the valid
// bit of the last one; the block takes one pixel every cycle while the receiver keeps i_ready high.
// When the receiver stalls, each stage holds its pixel and accepts a new one only
// when it is empty or hands its pixel on in the same cycle, so no pixel is lost or repeated.
// Correction registers are written through i_cfg_we / i_cfg_idx / i_cfg_data, take effect
// immediately and should change only while the pipeline is empty; index three is ignored.
// Synchronous active-low reset empties the pipeline and sets every correction to 255.
// White is never color corrected.
`default_nettype none
module hsv_to_rgbw_rainbow (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_hue,
    input  wire logic [7:0]  i_saturation,
    input  wire logic [7:0]  i_brightness,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_red_out,
    output logic [7:0]       o_green_out,
    output logic [7:0]       o_blue_out,
    output logic [7:0]       o_white_out,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data
);
    import hsvrgbw_pkg::*;

    logic [7:0] r_corr_red;
    logic [7:0] r_corr_green;
    logic [7:0] r_corr_blue;

    logic       s1_valid, s1_ready;
    t_pix       s1_pix;
    logic [7:0] s1_sat, s1_vid;
    logic       s2_valid, s2_ready;
    t_pix       s2_pix;
    logic [7:0] s2_vid;
    logic       s3_valid, s3_ready;
    t_pix       s3_pix;
    logic [7:0] s3_side;
    t_pix       s4_pix;
    logic [7:0] s4_side;
    t_pix       sat_scl, vid_scl, corr_scl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corr_red   <= CORR_RESET;
            r_corr_green <= CORR_RESET;
            r_corr_blue  <= CORR_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CORR_RED:   r_corr_red   <= i_cfg_data;
                CFG_CORR_GREEN: r_corr_green <= i_cfg_data;
                CFG_CORR_BLUE:  r_corr_blue  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    hsvrgbw_sector u_sector (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_valid      (s1_valid),
        .i_ready      (s1_ready),
        .o_pix        (s1_pix),
        .o_sat        (s1_sat),
        .o_vid        (s1_vid)
    );

    // White already holds 255 - saturation, so it passes the saturation stage unchanged.
    assign sat_scl = '{r: s1_sat, g: s1_sat, b: s1_sat, w: SCALE_UNITY};

    hsvrgbw_scale u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_pix   (s1_pix),
        .i_scl   (sat_scl),
        .i_side  (s1_vid),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_pix   (s2_pix),
        .o_side  (s2_vid)
    );

    assign vid_scl = '{r: s2_vid, g: s2_vid, b: s2_vid, w: s2_vid};

    hsvrgbw_scale u_dim (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_pix   (s2_pix),
        .i_scl   (vid_scl),
        .i_side  (8'd0),
        .o_valid (s3_valid),
        .i_ready (s3_ready),
        .o_pix   (s3_pix),
        .o_side  (s3_side)
    );

    assign corr_scl = '{r: r_corr_red, g: r_corr_green, b: r_corr_blue, w: SCALE_UNITY};

    hsvrgbw_scale u_corr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s3_valid),
        .o_ready (s3_ready),
        .i_pix   (s3_pix),
        .i_scl   (corr_scl),
        .i_side  (s3_side),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_pix   (s4_pix),
        .o_side  (s4_side)
    );

    assign o_red_out   = s4_pix.r;
    assign o_green_out = s4_pix.g;
    assign o_blue_out  = s4_pix.b;
    assign o_white_out = s4_pix.w | (s4_side & 8'd0);
endmodule
`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for hsv_to_rgbw_rainbow: directed, correction-register and random tests.
// Depends on hsvrgbw_pkg for the pixel struct, sector names and register indexes.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hsvrgbw_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int unsigned DRAIN_CYCLES = 8;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_hue = 8'd0;
    logic [7:0] i_saturation = 8'd0;
    logic [7:0] i_brightness = 8'd0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_red_out;
    logic [7:0] o_green_out;
    logic [7:0] o_blue_out;
    logic [7:0] o_white_out;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = CFG_CORR_RED;
    logic [7:0] i_cfg_data = 8'd0;

    // Correction values the block should hold right now.
    logic [7:0] corr_r = CORR_RESET;
    logic [7:0] corr_g = CORR_RESET;
    logic [7:0] corr_b = CORR_RESET;

    t_pix        expected_pixels[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    logic        send_idle = 1'b1;
    logic        recv_idle = 1'b1;
    int unsigned stall_left = 0;

    hsv_to_rgbw_rainbow dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_white_out  (o_white_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // (x * (s + 1)) / 256
    function automatic logic [7:0] attenuate(input logic [7:0] x, input logic [7:0] s);
        logic [16:0] wide;
        wide = {9'd0, x} * ({9'd0, s} + 17'd1);
        return wide[15:8];
    endfunction

    // Brightness curve: v*v/256, plus one for any nonzero v.
    function automatic logic [7:0] dim_curve(input logic [7:0] v);
        logic [15:0] sq;
        sq = {8'd0, v} * {8'd0, v};
        return sq[15:8] + ((v != 8'd0) ? 8'd1 : 8'd0);
    endfunction

    function automatic t_pix rainbow_pixel(input logic [7:0] hue, input logic [7:0] sat,
                                           input logic [7:0] bri);
        logic [7:0] ramp;
        logic [7:0] lvl;
        t_pix p;
        ramp = {hue[4:0], 3'b000} / 8'd3;
        case (t_sector'(hue[7:5]))
            SEC_RED_ORANGE:  begin p.r = 8'd255 - ramp;     p.g = ramp;
                                   p.b = 8'd0; end
            SEC_ORANGE_YEL:  begin p.r = 8'd171;            p.g = 8'd85 + ramp;
                                   p.b = 8'd0; end
            SEC_YEL_GREEN:   begin p.r = 8'd171 - {ramp[6:0], 1'b0}; p.g = 8'd170 + ramp;
                                   p.b = 8'd0; end
            SEC_GREEN_AQUA:  begin p.r = 8'd0;              p.g = 8'd255 - ramp;
                                   p.b = ramp; end
            SEC_AQUA_BLUE:   begin p.r = 8'd0;              p.g = 8'd171 - {ramp[6:0], 1'b0};
                                   p.b = 8'd85 + {ramp[6:0], 1'b0}; end
            SEC_BLUE_PURPLE: begin p.r = ramp;              p.g = 8'd0;
                                   p.b = 8'd255 - ramp; end
            SEC_PURPLE_PINK: begin p.r = 8'd85 + ramp;      p.g = 8'd0;
                                   p.b = 8'd171 - ramp; end
            default:         begin p.r = 8'd170 + ramp;     p.g = 8'd0;
                                   p.b = 8'd85 - ramp; end
        endcase

        // Desaturation moves the missing color into the white channel.
        if (sat == 8'd255) begin
            p.w = 8'd0;
        end else if (sat == 8'd0) begin
            p = '{r: 8'd0, g: 8'd0, b: 8'd0, w: 8'd255};
        end else begin
            p.r = attenuate(p.r, sat);
            p.g = attenuate(p.g, sat);
            p.b = attenuate(p.b, sat);
            p.w = 8'd255 - sat;
        end

        if (bri != 8'd255) begin
            lvl = dim_curve(bri);
            if (lvl == 8'd0) begin
                p = '0;
            end else begin
                p.r = attenuate(p.r, lvl);
                p.g = attenuate(p.g, lvl);
                p.b = attenuate(p.b, lvl);
                p.w = attenuate(p.w, lvl);
            end
        end

        p.r = attenuate(p.r, corr_r);
        p.g = attenuate(p.g, corr_g);
        p.b = attenuate(p.b, corr_b);
        return p;
    endfunction

    task automatic send_pixel(input logic [7:0] hue, input logic [7:0] sat,
                              input logic [7:0] bri);
        int unsigned gap;
        gap = send_idle ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_hue        <= hue;
        i_saturation <= sat;
        i_brightness <= bri;
        expected_pixels.push_back(rainbow_pixel(hue, sat, bri));
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic drain_pipeline();
        i_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_correction(input t_cfg_idx idx, input logic [7:0] value);
        drain_pipeline();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_CORR_RED:   corr_r = value;
            CFG_CORR_GREEN: corr_g = value;
            CFG_CORR_BLUE:  corr_b = value;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_all_corrections(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
        set_correction(CFG_CORR_RED, r);
        set_correction(CFG_CORR_GREEN, g);
        set_correction(CFG_CORR_BLUE, b);
    endtask

    // Extremes of every field, both ends of each sector ramp, saturation and
    // brightness corners, all at the reset correction values.
    task automatic test_directed();
        for (int k = 0; k < 8; k++) begin
            send_pixel({k[2:0], 5'h00}, 8'd255, 8'd255);
            send_pixel({k[2:0], 5'h1F}, 8'd255, 8'd255);
        end
        send_pixel(8'h4A, 8'd0, 8'd255);
        send_pixel(8'h4A, 8'd1, 8'd255);
        send_pixel(8'hB5, 8'd254, 8'd255);
        send_pixel(8'h2C, 8'd255, 8'd0);
        send_pixel(8'h2C, 8'd255, 8'd1);
        send_pixel(8'hD3, 8'd255, 8'd254);
        send_pixel(8'h00, 8'd0, 8'd0);
        send_pixel(8'hFF, 8'd128, 8'd16);
    endtask

    // Correction registers at zero, one and alternating bit patterns, and a
    // write to the unused index that must leave the registers untouched.
    task automatic test_correction();
        set_all_corrections(8'd0, 8'd0, 8'd0);
        for (int k = 0; k < 8; k++) send_pixel({k[2:0], 5'h10}, 8'd255, 8'd255);
        set_correction(CFG_UNUSED, 8'd255);
        send_pixel(8'h10, 8'd200, 8'd255);
        send_pixel(8'h90, 8'd255, 8'd200);
        set_all_corrections(8'd1, 8'hAA, 8'h55);
        for (int k = 0; k < 8; k++) send_pixel({k[2:0], 5'h07}, 8'd255, 8'd255);
        set_all_corrections(8'h55, 8'd128, 8'hAA);
        for (int k = 0; k < 8; k++) send_pixel({k[2:0], 5'h19}, 8'd180, 8'd230);
        set_correction(CFG_UNUSED, 8'd0);
        set_all_corrections(CORR_RESET, CORR_RESET, CORR_RESET);
        send_pixel(8'h60, 8'd255, 8'd255);
    endtask

    task automatic test_random();
        logic [7:0] sat;
        logic [7:0] bri;
        for (int phase = 0; phase < 8; phase++) begin
            if (phase == 0) begin
                set_all_corrections(8'd255, 8'd0, 8'd255);
            end else if (phase == 1) begin
                set_all_corrections(8'd0, 8'd255, 8'd0);
            end else begin
                set_all_corrections(8'($urandom), 8'($urandom), 8'($urandom));
            end
            for (int n = 0; n < 250; n++) begin
                // Change the idling pattern every 50 transactions, sometimes with none at all.
                if (n % 50 == 0) begin
                    send_idle = ($urandom_range(0, 3) != 0);
                    recv_idle = ($urandom_range(0, 3) != 0);
                end
                case ($urandom_range(0, 9))
                    0: sat = 8'd0;
                    1, 2: sat = 8'd255;
                    3: sat = 8'd1;
                    default: sat = 8'($urandom);
                endcase
                case ($urandom_range(0, 9))
                    0: bri = 8'd0;
                    1, 2: bri = 8'd255;
                    3: bri = 8'd1;
                    default: bri = 8'($urandom);
                endcase
                send_pixel(8'($urandom), sat, bri);
            end
        end
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    // Receiver: after each transaction, drop ready for a randomly drawn stall while recv_idle is set.
    always @(posedge i_clk) begin : ready_gen
        int unsigned n;
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_left <= 0;
        end else if (o_valid && i_ready) begin
            n = recv_idle ? $urandom_range(0, 3) : 0;
            stall_left <= n;
            i_ready    <= (n == 0);
        end else begin
            if (stall_left != 0) stall_left <= stall_left - 1;
            i_ready <= (stall_left <= 1);
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_pix want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected output transaction: r=%0d g=%0d b=%0d w=%0d",
                       o_red_out, o_green_out, o_blue_out, o_white_out);
                mismatch_count++;
            end else begin
                want = expected_pixels.pop_front();
                check_field("red_out", want.r, o_red_out);
                check_field("green_out", want.g, o_green_out);
                check_field("blue_out", want.b, o_blue_out);
                check_field("white_out", want.w, o_white_out);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("hsv_to_rgbw_rainbow regression: fail");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_correction();
        test_random();
        drain_pipeline();
        // Any stray output after the last expected pixel is flagged by the checker.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("hsv_to_rgbw_rainbow regression: pass");
        end else begin
            $display("hsv_to_rgbw_rainbow regression: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* filelist.f */
hdl/hsvrgbw_pkg.sv
hdl/hsvrgbw_sector.sv
hdl/hsvrgbw_scale.sv
hdl/hsv_to_rgbw_rainbow.sv
dv/tb.sv
